@@ design/isfp_pkg.sv @@
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants for the IMU sample frame packer.
// ----------------------------------------------------------------------------
package isfp_pkg;

    localparam int FRAME_BYTES = 17;
    localparam int VALUE_COUNT = 7;
    localparam int VALUE_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = VALUE_COUNT * VALUE_W;

    localparam logic [BYTE_W-1:0] HEAD_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'h55;

    // What a frame slot carries
    typedef enum logic [1:0] {
        KIND_HEAD  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_SUM   = 2'd2
    } slot_kind_t;

    // Contents of one cell of the byte chain
    typedef struct packed {
        logic              valid;
        slot_kind_t        kind;
        logic [BYTE_W-1:0] data;
    } slot_t;

    // Control from the top level to every cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ design/imu_sample_frame_packer.sv @@
// ----------------------------------------------------------------------------
// imu_sample_frame_packer
// Turn one seven-value IMU sample into a 17-byte framed, checksummed stream.
// ----------------------------------------------------------------------------
// Each accepted sample word is loaded at once into a row of 17 byte cells:
// header 0xAA, 0x55, then temperature, accel X/Y/Z and gyro X/Y/Z, each
// high byte first, then a checksum slot. The row shifts one cell toward the
// output every cycle the master side takes a word. The checksum slot is
// filled from a running 8-bit sum of the fourteen value bytes, built as they
// leave. The next sample is taken in the same cycle the checksum byte is
// taken, so frames follow each other with no gap. m_tlast marks the
// checksum byte. Nothing is kept between samples.
// ----------------------------------------------------------------------------
module imu_sample_frame_packer
    import isfp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata, low bit up: temperature, accel_x, accel_y, accel_z,
    //                      gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m_tdata: frame_byte (8 bits)
    output logic [BYTE_W-1:0]   m_tdata,
    output logic                m_tlast,
    output logic                m_tvalid,
    input  logic                m_tready
);

    slot_t      load_slot [FRAME_BYTES];
    slot_t      cell_slot [FRAME_BYTES];
    slot_t      empty_slot;
    cell_ctrl_t ctrl;
    logic       s_fire;
    logic       m_fire;

    // Head of the chain is cell 0; it drives the master side
    assign m_tvalid = cell_slot[0].valid;
    assign m_tlast  = cell_slot[0].kind == KIND_SUM;
    assign m_fire   = m_tvalid && m_tready;

    // Take a sample when the chain is empty or its last word is leaving
    assign s_tready = !cell_slot[0].valid || (m_fire && m_tlast);
    assign s_fire   = s_tvalid && s_tready;

    assign ctrl.load  = s_fire;
    assign ctrl.shift = m_fire;

    assign empty_slot = '{valid: 1'b0, kind: KIND_HEAD, data: '0};

    // Lay out the frame for a parallel load
    always_comb begin
        load_slot[0] = '{valid: 1'b1, kind: KIND_HEAD, data: HEAD_FIRST};
        load_slot[1] = '{valid: 1'b1, kind: KIND_HEAD, data: HEAD_SECOND};
        for (int v = 0; v < VALUE_COUNT; v++) begin
            load_slot[2 + 2*v] = '{valid: 1'b1, kind: KIND_VALUE,
                                   data: s_tdata[VALUE_W*v + BYTE_W +: BYTE_W]};
            load_slot[3 + 2*v] = '{valid: 1'b1, kind: KIND_VALUE,
                                   data: s_tdata[VALUE_W*v +: BYTE_W]};
        end
        load_slot[FRAME_BYTES-1] = '{valid: 1'b1, kind: KIND_SUM, data: '0};
    end

    for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
        isfp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .load_slot (load_slot[i]),
            .prev_slot ((i == FRAME_BYTES-1) ? empty_slot : cell_slot[(i+1) % FRAME_BYTES]),
            .slot      (cell_slot[i])
        );
    end

    isfp_csum u_csum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (m_fire),
        .head_slot (cell_slot[0]),
        .out_byte  (m_tdata)
    );

endmodule

@@ design/isfp_cell.sv @@
// ----------------------------------------------------------------------------
// isfp_cell
// One byte slot of the frame chain: load in parallel or take the neighbor.
// ----------------------------------------------------------------------------
module isfp_cell
    import isfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  slot_t      load_slot,
    input  slot_t      prev_slot,
    output slot_t      slot
);

    logic              valid_reg,  valid_next;
    slot_kind_t        kind_reg,   kind_next;
    logic [BYTE_W-1:0] data_reg,   data_next;

    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        if (ctrl.load) begin
            valid_next = load_slot.valid;
            kind_next  = load_slot.kind;
            data_next  = load_slot.data;
        end else if (ctrl.shift) begin
            valid_next = prev_slot.valid;
            kind_next  = prev_slot.kind;
            data_next  = prev_slot.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        data_reg <= data_next;
    end

    assign slot = '{valid: valid_reg, kind: kind_reg, data: data_reg};

endmodule

@@ design/isfp_csum.sv @@
// ----------------------------------------------------------------------------
// isfp_csum
// Running 8-bit checksum over the value bytes as they leave the chain.
// ----------------------------------------------------------------------------
module isfp_csum
    import isfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  slot_t             head_slot,
    output logic [BYTE_W-1:0] out_byte
);

    logic [BYTE_W-1:0] sum_reg, sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (fire) begin
            case (head_slot.kind)
                KIND_HEAD:  sum_next = '0;
                KIND_VALUE: sum_next = sum_reg + head_slot.data;
                default:    sum_next = sum_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    // Substitute the sum on the closing slot
    assign out_byte = (head_slot.kind == KIND_SUM) ? sum_reg : head_slot.data;

endmodule
